[rtl/unwarp_remap_grid_generator_macros.svh]
// ----------------------------------------------------------------------------
// unwarp remap grid generator assertion macros
// shared property forms for the grid generator checks
// ----------------------------------------------------------------------------
`ifndef UNWARP_REMAP_GRID_GENERATOR_MACROS_SVH
`define UNWARP_REMAP_GRID_GENERATOR_MACROS_SVH

// same-cycle implication
`define URG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define URG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/urg_pkg.sv]
// ----------------------------------------------------------------------------
// urg_pkg
// shared constants, codes and types of the remap grid generator
// ----------------------------------------------------------------------------
`default_nettype none

package urg_pkg;

    // grid geometry
    localparam int GRID_SIZE   = 160;
    localparam int MARGIN      = 25;
    localparam int SIDE        = GRID_SIZE - 2 * MARGIN;
    localparam int TABLE_DEPTH = 128;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int TAB_COUNT   = 6;
    localparam int TAB_SEL_W   = 3;

    // table select codes
    localparam logic [TAB_SEL_W-1:0] TAB_LEFT   = 3'd0;
    localparam logic [TAB_SEL_W-1:0] TAB_BOTTOM = 3'd1;
    localparam logic [TAB_SEL_W-1:0] TAB_RIGHT  = 3'd2;
    localparam logic [TAB_SEL_W-1:0] TAB_TOP    = 3'd3;
    localparam logic [TAB_SEL_W-1:0] TAB_WARP_X = 3'd4;
    localparam logic [TAB_SEL_W-1:0] TAB_WARP_Y = 3'd5;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARP_ENABLE  = 2'd2;
    localparam int RST_INPUT_SIZE   = 160;
    localparam int RST_INPUT_MARGIN = 16;

    // field widths
    localparam int SIZE_W   = 10;
    localparam int MARGIN_W = 9;
    localparam int GRID_W   = 8;
    localparam int ENTRY_W  = 16;
    localparam int OUT_W    = 21;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 48;
    localparam int OP_BIT    = 0;
    localparam int SEL_LSB   = 1;
    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + TAB_AW;
    localparam int GX_LSB    = VAL_LSB + ENTRY_W;
    localparam int GY_LSB    = GX_LSB + GRID_W;

    // datapath widths
    localparam int COORD_W   = 9;
    localparam int SPAN_W    = 11;
    localparam int PROD_W    = 20;
    localparam int FRAC_BITS = 8;

    // scale term: (c - margin) * span * 128 / 55
    localparam int SCALE_SH  = 7;
    localparam int P_DIV     = 55;
    localparam int P_BIAS_SH = 20;
    localparam int XP_W      = 27;
    localparam int P_RECIP_W = 28;
    localparam logic [P_RECIP_W-1:0] P_RECIP = 28'd156180629;
    localparam int RECIP_SH  = 33;
    localparam int QP_W      = 21;
    localparam int P_REM_W   = 6;

    // blend term: q / (SIDE - 1)
    localparam int Q_W       = 25;
    localparam int Q_DIV     = SIDE - 1;
    localparam int Q_BIAS_SH = 18;
    localparam int XQ_W      = 26;
    localparam int Q_RECIP_W = 27;
    localparam logic [Q_RECIP_W-1:0] Q_RECIP = 27'd78806740;
    localparam int QQ_W      = 19;
    localparam int Q_REM_W   = 7;

    // warp term: w * 55 / 64
    localparam int R_W   = 22;
    localparam int R_MUL = 55;
    localparam int R_SH  = 6;

    // remainder recombination over a common denominator of 55 * 109 * 64
    localparam int FRAC_W    = 21;
    localparam int W_P       = 6976;
    localparam int W_Q       = 3520;
    localparam int W_R       = 5995;
    localparam int FRAC_ONE  = 383680;
    localparam int FRAC_HALF = 191840;

    localparam int SUM_W   = 24;
    localparam int OUT_MAX = 1048575;
    localparam int OUT_MIN = -1048576;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] left;
        logic signed [ENTRY_W-1:0] bottom;
        logic signed [ENTRY_W-1:0] right;
        logic signed [ENTRY_W-1:0] top;
        logic signed [ENTRY_W-1:0] warp_x;
        logic signed [ENTRY_W-1:0] warp_y;
    } t_tab_rd;

endpackage

`default_nettype wire

[rtl/urg_tables.sv]
// ----------------------------------------------------------------------------
// urg_tables
// six offset and warp tables, one write port and one registered read each
// ----------------------------------------------------------------------------
`default_nettype none

module urg_tables (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [urg_pkg::TAB_SEL_W-1:0] i_wr_sel,
    input  logic [urg_pkg::TAB_AW-1:0]    i_wr_addr,
    input  logic [urg_pkg::ENTRY_W-1:0]   i_wr_data,
    input  logic                          i_rd_en,
    input  logic [urg_pkg::GRID_W-1:0]    i_grid_x,
    input  logic [urg_pkg::GRID_W-1:0]    i_grid_y,
    output urg_pkg::t_tab_rd              o_rd
);
    import urg_pkg::*;

    logic [TAB_AW-1:0]  px;
    logic [TAB_AW-1:0]  py;
    logic [TAB_AW-1:0]  pxr;
    logic [TAB_AW-1:0]  pyr;
    logic [TAB_AW-1:0]  rd_addr [TAB_COUNT];
    logic [ENTRY_W-1:0] r_rd    [TAB_COUNT];

    // band positions, reversed for the far side
    always_comb begin
        px  = TAB_AW'(i_grid_x - GRID_W'(MARGIN));
        py  = TAB_AW'(i_grid_y - GRID_W'(MARGIN));
        pxr = TAB_AW'(SIDE - 1) - px;
        pyr = TAB_AW'(SIDE - 1) - py;
        rd_addr[TAB_LEFT]   = py;
        rd_addr[TAB_RIGHT]  = pyr;
        rd_addr[TAB_BOTTOM] = px;
        rd_addr[TAB_TOP]    = pxr;
        rd_addr[TAB_WARP_X] = px;
        rd_addr[TAB_WARP_Y] = py;
    end

    for (genvar t = 0; t < TAB_COUNT; t++) begin : g_tab
        logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_wr_en && i_wr_sel == TAB_SEL_W'(t)) begin
                r_mem[i_wr_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd[t] <= r_mem[rd_addr[t]];
            end
        end
    end

    always_comb begin
        o_rd.left   = r_rd[TAB_LEFT];
        o_rd.bottom = r_rd[TAB_BOTTOM];
        o_rd.right  = r_rd[TAB_RIGHT];
        o_rd.top    = r_rd[TAB_TOP];
        o_rd.warp_x = r_rd[TAB_WARP_X];
        o_rd.warp_y = r_rd[TAB_WARP_Y];
    end

endmodule

`default_nettype wire

[rtl/urg_axis.sv]
// ----------------------------------------------------------------------------
// urg_axis
// five-stage datapath for one source coordinate: scale, blend, warp,
// exact division by constants, rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module urg_axis (
    input  logic                              i_clk,
    input  urg_pkg::t_stage_en                i_en,
    input  logic [urg_pkg::GRID_W-1:0]        i_coord,
    input  logic [urg_pkg::GRID_W-1:0]        i_other,
    input  logic signed [urg_pkg::SPAN_W-1:0] i_span,
    input  logic [urg_pkg::MARGIN_W-1:0]      i_margin,
    input  logic                              i_warp_en,
    input  logic signed [urg_pkg::ENTRY_W-1:0] i_near,
    input  logic signed [urg_pkg::ENTRY_W-1:0] i_far,
    input  logic signed [urg_pkg::ENTRY_W-1:0] i_warp,
    output logic signed [urg_pkg::OUT_W-1:0]  o_source
);
    import urg_pkg::*;

    // stage 1
    logic signed [COORD_W-1:0] n_wc;
    logic signed [PROD_W-1:0]  n_m;
    logic                      n_band_c;
    logic                      n_band_o;
    logic signed [COORD_W-1:0] r1_wc;
    logic signed [PROD_W-1:0]  r1_m;
    logic                      r1_band_o;
    logic                      r1_warp_on;

    // stage 2
    logic signed [COORD_W-1:0] wrev;
    logic signed [Q_W-1:0]     n_q;
    logic signed [R_W-1:0]     n_r;
    logic signed [XP_W:0]      xp_s;
    logic signed [Q_W-1:0]     r2_q;
    logic signed [R_W-1:0]     r2_r;
    logic [XP_W-1:0]           r2_xp;

    // stage 3
    logic signed [XQ_W:0]              xq_s;
    logic [XQ_W-1:0]                   n_xq;
    logic [XP_W+P_RECIP_W-1:0]         prod_p;
    logic [XQ_W+Q_RECIP_W-1:0]         prod_q;
    logic [QP_W-1:0]                   r3_qp_b;
    logic [QQ_W-1:0]                   r3_qq_b;
    logic [XP_W-1:0]                   r3_xp;
    logic [XQ_W-1:0]                   r3_xq;
    logic signed [R_W-1:0]             r3_r;

    // stage 4
    logic [XP_W-1:0]           rp_full;
    logic [XQ_W-1:0]           rq_full;
    logic signed [QP_W:0]      qp;
    logic signed [QQ_W:0]      qq;
    logic signed [SUM_W-1:0]   n_int;
    logic signed [SUM_W-1:0]   r4_int;
    logic [P_REM_W-1:0]        r4_rp;
    logic [Q_REM_W-1:0]        r4_rq;
    logic [R_SH-1:0]           r4_rr;

    // stage 5
    logic [FRAC_W-1:0]         frac;
    logic [1:0]                cnt;
    logic signed [SUM_W-1:0]   total;
    logic signed [SUM_W-1:0]   sat;
    logic signed [OUT_W-1:0]   r5_out;

    always_comb begin
        n_wc     = $signed({1'b0, i_coord}) - COORD_W'(MARGIN);
        n_m      = PROD_W'(n_wc) * PROD_W'(i_span);
        n_band_c = (i_coord >= GRID_W'(MARGIN)) && (i_coord < GRID_W'(MARGIN + SIDE));
        n_band_o = (i_other >= GRID_W'(MARGIN)) && (i_other < GRID_W'(MARGIN + SIDE));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_wc      <= n_wc;
            r1_m       <= n_m;
            r1_band_o  <= n_band_o;
            r1_warp_on <= i_warp_en && n_band_c;
        end
    end

    always_comb begin
        wrev = COORD_W'(SIDE - 1) - r1_wc;
        n_q  = '0;
        if (r1_band_o) begin
            n_q = Q_W'(i_far) * Q_W'(r1_wc) - Q_W'(i_near) * Q_W'(wrev);
        end
        n_r = '0;
        if (r1_warp_on) begin
            n_r = R_W'(i_warp) * R_W'(R_MUL);
        end
        // biased so the floor division works on a positive value
        xp_s = ((XP_W + 1)'(r1_m) <<< SCALE_SH) + (XP_W + 1)'(P_DIV * (1 << P_BIAS_SH));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_q  <= n_q;
            r2_r  <= n_r;
            r2_xp <= xp_s[XP_W-1:0];
        end
    end

    always_comb begin
        xq_s   = (XQ_W + 1)'(r2_q) + (XQ_W + 1)'(Q_DIV * (1 << Q_BIAS_SH));
        n_xq   = xq_s[XQ_W-1:0];
        prod_p = (XP_W + P_RECIP_W)'(r2_xp) * (XP_W + P_RECIP_W)'(P_RECIP);
        prod_q = (XQ_W + Q_RECIP_W)'(n_xq) * (XQ_W + Q_RECIP_W)'(Q_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_qp_b <= prod_p[RECIP_SH +: QP_W];
            r3_qq_b <= prod_q[RECIP_SH +: QQ_W];
            r3_xp   <= r2_xp;
            r3_xq   <= n_xq;
            r3_r    <= r2_r;
        end
    end

    always_comb begin
        rp_full = r3_xp - XP_W'(r3_qp_b) * XP_W'(P_DIV);
        rq_full = r3_xq - XQ_W'(r3_qq_b) * XQ_W'(Q_DIV);
        qp      = $signed({1'b0, r3_qp_b}) - (QP_W + 1)'(1 << P_BIAS_SH);
        qq      = $signed({1'b0, r3_qq_b}) - (QQ_W + 1)'(1 << Q_BIAS_SH);
        n_int   = (SUM_W'($signed({1'b0, i_margin})) <<< FRAC_BITS)
                + SUM_W'(qp) + SUM_W'(qq) + SUM_W'(r3_r >>> R_SH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_int <= n_int;
            r4_rp  <= rp_full[P_REM_W-1:0];
            r4_rq  <= rq_full[Q_REM_W-1:0];
            r4_rr  <= r3_r[R_SH-1:0];
        end
    end

    // round half up over the summed fractions, then clamp
    always_comb begin
        frac = FRAC_W'(r4_rp) * FRAC_W'(W_P) + FRAC_W'(r4_rq) * FRAC_W'(W_Q)
             + FRAC_W'(r4_rr) * FRAC_W'(W_R) + FRAC_W'(FRAC_HALF);
        cnt  = 2'(frac >= FRAC_W'(FRAC_ONE)) + 2'(frac >= FRAC_W'(2 * FRAC_ONE))
             + 2'(frac >= FRAC_W'(3 * FRAC_ONE));
        total = r4_int + $signed(SUM_W'(cnt));
        sat   = total;
        if (total > SUM_W'(OUT_MAX)) begin
            sat = SUM_W'(OUT_MAX);
        end else if (total < SUM_W'(OUT_MIN)) begin
            sat = SUM_W'(OUT_MIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r5_out <= sat[OUT_W-1:0];
        end
    end

    assign o_source = r5_out;

endmodule

`default_nettype wire

[rtl/unwarp_remap_grid_generator.sv]
// ----------------------------------------------------------------------------
// unwarp_remap_grid_generator
// remap grid generator with loadable side offset and warp tables
// ----------------------------------------------------------------------------
// Takes one word per clock on the slave stream, loads and queries alike,
// unless the master stream holds the pipeline off. A load writes one table
// entry at the edge it is accepted and returns nothing; the next word may
// already query that entry. A query returns its source_x and source_y word
// on the master stream, and a new query can follow every cycle unless the
// output stalls: each of the six tables is one memory read once per query,
// and the arithmetic runs as a five-stage pipeline whose stages advance
// independently, so bubbles close up under backpressure. Configuration is
// taken on any cycle and is meant to change only while no query is in flight.
`default_nettype none
`include "unwarp_remap_grid_generator_macros.svh"

module unwarp_remap_grid_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index, entry_value, grid_x, grid_y, zero pad
    input  logic [urg_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation, table_select
    input  logic [urg_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // source_x, source_y, zero pad
    output logic [urg_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [urg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [urg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import urg_pkg::*;

    logic                      op;
    logic [TAB_SEL_W-1:0]      sel;
    logic [TAB_AW-1:0]         entry_index;
    logic [ENTRY_W-1:0]        entry_value;
    logic [GRID_W-1:0]         grid_x;
    logic [GRID_W-1:0]         grid_y;
    logic                      accept;

    logic [SIZE_W-1:0]         r_input_size;
    logic [MARGIN_W-1:0]       r_input_margin;
    logic                      r_warp_enable;
    logic signed [SPAN_W-1:0]  span;

    t_stage_en                 st_en;
    logic [5:1]                r_valid;
    t_tab_rd                   tab_rd;
    logic signed [OUT_W-1:0]   source_x;
    logic signed [OUT_W-1:0]   source_y;

    always_comb begin
        op          = s_axis_tuser[OP_BIT];
        sel         = s_axis_tuser[SEL_LSB +: TAB_SEL_W];
        entry_index = s_axis_tdata[IDX_LSB +: TAB_AW];
        entry_value = s_axis_tdata[VAL_LSB +: ENTRY_W];
        grid_x      = s_axis_tdata[GX_LSB +: GRID_W];
        grid_y      = s_axis_tdata[GY_LSB +: GRID_W];
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_size   <= SIZE_W'(RST_INPUT_SIZE);
            r_input_margin <= MARGIN_W'(RST_INPUT_MARGIN);
            r_warp_enable  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INPUT_SIZE:   r_input_size   <= i_cfg_data[SIZE_W-1:0];
                CFG_INPUT_MARGIN: r_input_margin <= i_cfg_data[MARGIN_W-1:0];
                CFG_WARP_ENABLE:  r_warp_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign span = $signed({1'b0, r_input_size}) - $signed({1'b0, r_input_margin, 1'b0});

    // per-stage advance, each stage loads when empty or when it drains
    always_comb begin
        st_en.s5 = !r_valid[5] || m_axis_tready;
        st_en.s4 = !r_valid[4] || st_en.s5;
        st_en.s3 = !r_valid[3] || st_en.s4;
        st_en.s2 = !r_valid[2] || st_en.s3;
        st_en.s1 = !r_valid[1] || st_en.s2;
    end

    assign s_axis_tready = st_en.s1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (st_en.s1) begin
                r_valid[1] <= s_axis_tvalid && op == OP_QUERY;
            end
            if (st_en.s2) begin
                r_valid[2] <= r_valid[1];
            end
            if (st_en.s3) begin
                r_valid[3] <= r_valid[2];
            end
            if (st_en.s4) begin
                r_valid[4] <= r_valid[3];
            end
            if (st_en.s5) begin
                r_valid[5] <= r_valid[4];
            end
        end
    end

    urg_tables u_tables (
        .i_clk     (i_clk),
        .i_wr_en   (accept && op == OP_LOAD),
        .i_wr_sel  (sel),
        .i_wr_addr (entry_index),
        .i_wr_data (entry_value),
        .i_rd_en   (st_en.s1),
        .i_grid_x  (grid_x),
        .i_grid_y  (grid_y),
        .o_rd      (tab_rd)
    );

    urg_axis u_axis_x (
        .i_clk     (i_clk),
        .i_en      (st_en),
        .i_coord   (grid_x),
        .i_other   (grid_y),
        .i_span    (span),
        .i_margin  (r_input_margin),
        .i_warp_en (r_warp_enable),
        .i_near    (tab_rd.left),
        .i_far     (tab_rd.right),
        .i_warp    (tab_rd.warp_x),
        .o_source  (source_x)
    );

    urg_axis u_axis_y (
        .i_clk     (i_clk),
        .i_en      (st_en),
        .i_coord   (grid_y),
        .i_other   (grid_x),
        .i_span    (span),
        .i_margin  (r_input_margin),
        .i_warp_en (r_warp_enable),
        .i_near    (tab_rd.top),
        .i_far     (tab_rd.bottom),
        .i_warp    (tab_rd.warp_y),
        .o_source  (source_y)
    );

    assign m_axis_tvalid = r_valid[5];
    assign m_axis_tdata  = {(M_TDATA_W - 2 * OUT_W)'(0), source_y, source_x};

    `URG_ASSERT_NEXT(a_query_enters, i_clk, i_rst_n, accept && op == OP_QUERY, r_valid[1], "accepted query did not enter the pipeline")
    `URG_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, accept && op == OP_LOAD, !r_valid[1], "load word produced a pipeline entry")
    `URG_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_valid[4] && !st_en.s5, r_valid[4] && r_valid[5], "stalled stage lost its word")
    `URG_ASSERT_SAME(a_ready_room, i_clk, i_rst_n, !s_axis_tready, (&r_valid) && !m_axis_tready, "input stalled while the pipeline had room")

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the remap grid generator
// ----------------------------------------------------------------------------
// Preloads every entry of the six offset and warp tables and then sends
// table loads and grid queries through the slave stream. Each query is
// predicted from a local copy of the tables and the configuration, and
// the master stream output is checked in order against those predictions.
// Both streams idle at random. One phase holds the output off long enough
// to stall the input, and one phase runs with no idling at all. The
// configuration is rewritten between phases, covering the extremes and a
// negative span.
// ----------------------------------------------------------------------------
module tb_top;
    import urg_pkg::*;

    localparam int  RX_HOLD_CYCLES = 300;
    localparam int  DRAIN_CYCLES   = 12;
    localparam int  PHASE_WORDS    = 65;
    localparam int  REPORT_LIMIT   = 10;
    localparam longint SCALE_DIV   = (SIDE < 1) ? 1 : SIDE;
    localparam longint BLEND_DIV   = (SIDE < 2) ? 1 : SIDE - 1;
    localparam logic [TAB_SEL_W-1:0] SEL_SPARE_LO = 3'd6;
    localparam logic [TAB_SEL_W-1:0] SEL_SPARE_HI = 3'd7;
    localparam logic [ENTRY_W-1:0]   ENTRY_MIN    = 16'h8000;
    localparam logic [ENTRY_W-1:0]   ENTRY_MAX    = 16'h7FFF;

    typedef struct {
        logic                  op;
        logic [TAB_SEL_W-1:0]  sel;
        logic [TAB_AW-1:0]     idx;
        logic [ENTRY_W-1:0]    val;
        logic [GRID_W-1:0]     gx;
        logic [GRID_W-1:0]     gy;
    } t_grid_word;

    typedef struct {
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
    } t_source_pt;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    t_grid_word word_q[$];
    t_source_pt source_q[$];

    logic signed [ENTRY_W-1:0] entry_store [TAB_COUNT][TABLE_DEPTH];
    logic [SIZE_W-1:0]         cur_size   = SIZE_W'(RST_INPUT_SIZE);
    logic [MARGIN_W-1:0]       cur_margin = MARGIN_W'(RST_INPUT_MARGIN);
    logic                      cur_warp   = 1'b0;

    bit word_taken  = 1'b0;
    bit no_idle     = 1'b0;
    bit rx_hold_req = 1'b0;
    int tx_gap_left  = 0;
    int rx_gap_left  = 0;
    int rx_hold_left = 0;
    int fail_count   = 0;

    unwarp_remap_grid_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[unwarp_remap_grid_generator] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (no_idle || roll < 65)
            return 0;
        else if (roll < 90)
            return $urandom_range(3, 1);
        else if (roll < 98)
            return $urandom_range(10, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    function automatic longint side_entry(int tab, longint pos);
        if (pos < 0 || pos >= SIDE || pos >= TABLE_DEPTH)
            return 0;
        return longint'(entry_store[tab][pos]);
    endfunction

    // exact rational in Q8 units, rounded half up, then saturated
    function automatic logic [OUT_W-1:0] axis_source(longint c, longint o, int near_tab,
                                                     int far_tab, bit rev_near, int warp_tab);
        longint den, span, num, p, pr, nv, fv, w, q;
        den  = SCALE_DIV * BLEND_DIV * 128;
        span = longint'(cur_size) - 2 * longint'(cur_margin);
        num  = (c - MARGIN) * span * 256 * BLEND_DIV * 128 + longint'(cur_margin) * 256 * den;
        p    = o - MARGIN;
        pr   = SIDE - 1 - p;
        w    = c - MARGIN;
        if (SIDE >= 1 && p >= 0 && p < SIDE) begin
            nv = side_entry(near_tab, rev_near ? pr : p);
            fv = side_entry(far_tab, rev_near ? p : pr);
            num += (fv * w - nv * (BLEND_DIV - w)) * SCALE_DIV * 128;
        end
        if (cur_warp && SIDE >= 1 && w >= 0 && w < SIDE)
            num += side_entry(warp_tab, w) * SIDE * SCALE_DIV * BLEND_DIV;
        num = 2 * num + den;
        den = 2 * den;
        q   = num / den;
        if (num % den != 0 && num < 0)
            q = q - 1;
        if (q > OUT_MAX)
            q = OUT_MAX;
        if (q < OUT_MIN)
            q = OUT_MIN;
        return q[OUT_W-1:0];
    endfunction

    function automatic void take_word(t_grid_word wd);
        t_source_pt pt;
        if (wd.op == OP_QUERY) begin
            pt.sx = axis_source(wd.gx, wd.gy, TAB_LEFT, TAB_RIGHT, 1'b0, TAB_WARP_X);
            pt.sy = axis_source(wd.gy, wd.gx, TAB_TOP, TAB_BOTTOM, 1'b1, TAB_WARP_Y);
            source_q.insert(source_q.size(), pt);
        end else if (wd.sel < TAB_COUNT) begin
            entry_store[wd.sel][wd.idx] = wd.val;
        end
    endfunction

    // input stream driver
    always @(negedge i_clk) begin
        t_grid_word wd;
        if (i_rst_n && (!s_axis_tvalid || word_taken)) begin
            if (word_taken) begin
                word_taken  = 1'b0;
                tx_gap_left = pick_gap();
            end
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (word_q.size() > 0) begin
                wd = word_q[0];
                s_axis_tdata  <= S_TDATA_W'({wd.gy, wd.gx, wd.val, wd.idx});
                s_axis_tuser  <= S_TUSER_W'({wd.sel, wd.op});
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            take_word(word_q.pop_front());
            word_taken = 1'b1;
        end
    end

    // output stream backpressure
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap_left = pick_gap();
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_source_pt       want;
        logic [OUT_W-1:0] got_x;
        logic [OUT_W-1:0] got_y;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_x = m_axis_tdata[OUT_W-1:0];
            got_y = m_axis_tdata[2*OUT_W-1:OUT_W];
            if (source_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected word: x %0d y %0d", $signed(got_x), $signed(got_y));
            end else begin
                want = source_q.pop_front();
                if (got_x !== want.sx || got_y !== want.sy) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: expected x %0d y %0d, got x %0d y %0d",
                                 $signed(want.sx), $signed(want.sy),
                                 $signed(got_x), $signed(got_y));
                end
            end
        end
    end

    task automatic push_load(logic [TAB_SEL_W-1:0] sel, int idx, logic [ENTRY_W-1:0] val);
        t_grid_word wd;
        wd.op  = OP_LOAD;
        wd.sel = sel;
        wd.idx = TAB_AW'(idx);
        wd.val = val;
        wd.gx  = GRID_W'($urandom);
        wd.gy  = GRID_W'($urandom);
        word_q.insert(word_q.size(), wd);
    endtask

    task automatic push_query(int gx, int gy);
        t_grid_word wd;
        wd.op  = OP_QUERY;
        wd.sel = TAB_SEL_W'($urandom);
        wd.idx = TAB_AW'($urandom);
        wd.val = ENTRY_W'($urandom);
        wd.gx  = GRID_W'(gx);
        wd.gy  = GRID_W'(gy);
        word_q.insert(word_q.size(), wd);
    endtask

    function automatic logic [ENTRY_W-1:0] rand_entry();
        case ($urandom_range(9, 0))
            0:       return ENTRY_MIN;
            1:       return ENTRY_MAX;
            2:       return ENTRY_W'($urandom_range(512, 0) - 256);
            default: return ENTRY_W'($urandom);
        endcase
    endfunction

    function automatic int rand_grid();
        if ($urandom_range(4, 0) != 0)
            return $urandom_range(GRID_SIZE - 1, 0);
        case ($urandom_range(5, 0))
            0:       return 0;
            1:       return MARGIN - 1;
            2:       return MARGIN;
            3:       return MARGIN + SIDE - 1;
            4:       return MARGIN + SIDE;
            default: return GRID_SIZE - 1;
        endcase
    endfunction

    task automatic push_random(int count);
        int done;
        int roll;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(99, 0);
            if (roll < 4) begin
                push_load(roll[0] ? SEL_SPARE_HI : SEL_SPARE_LO,
                          $urandom_range(TABLE_DEPTH - 1, 0), rand_entry());
            end else begin
                if (roll < 30)
                    push_load(TAB_SEL_W'($urandom_range(TAB_WARP_Y, TAB_LEFT)),
                              (roll < 7) ? $urandom_range(TABLE_DEPTH - 1, SIDE)
                                         : $urandom_range(SIDE - 1, 0),
                              rand_entry());
                else
                    push_query(rand_grid(), rand_grid());
                done++;
            end
        end
    endtask

    task automatic push_directed_queries();
        push_query(0, 0);
        push_query(GRID_SIZE - 1, GRID_SIZE - 1);
        push_query(0, GRID_SIZE - 1);
        push_query(GRID_SIZE - 1, 0);
        push_query(MARGIN, MARGIN);
        push_query(MARGIN + SIDE - 1, MARGIN + SIDE - 1);
        push_query(MARGIN, MARGIN + SIDE - 1);
        push_query(MARGIN + SIDE - 1, MARGIN);
        push_query(0, MARGIN);
        push_query(GRID_SIZE - 1, MARGIN + SIDE - 1);
        push_query(MARGIN - 1, MARGIN + SIDE);
        push_query(MARGIN + SIDE, MARGIN - 1);
        push_query(GRID_SIZE / 2, GRID_SIZE / 2);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_INPUT_SIZE:   cur_size   = SIZE_W'(value);
            CFG_INPUT_MARGIN: cur_margin = MARGIN_W'(value);
            CFG_WARP_ENABLE:  cur_warp   = value[0];
            default:          ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int size, int margin, bit warp);
        write_reg(CFG_INPUT_SIZE, size);
        write_reg(CFG_INPUT_MARGIN, margin);
        write_reg(CFG_WARP_ENABLE, warp);
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || source_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_geometry(RST_INPUT_SIZE, RST_INPUT_MARGIN, 1'b0);
        for (int t = 0; t < TAB_COUNT; t++)
            for (int i = 0; i < TABLE_DEPTH; i++)
                push_load(TAB_SEL_W'(t), i, rand_entry());
        push_load(TAB_LEFT, 0, ENTRY_MIN);
        push_load(TAB_RIGHT, SIDE - 1, ENTRY_MAX);
        push_load(TAB_TOP, SIDE - 1, ENTRY_MIN);
        push_load(TAB_BOTTOM, 0, ENTRY_MAX);
        push_load(TAB_WARP_X, 0, ENTRY_MIN);
        push_load(TAB_WARP_Y, SIDE - 1, ENTRY_MAX);
        push_load(SEL_SPARE_LO, 0, ENTRY_MAX);
        push_load(SEL_SPARE_HI, SIDE - 1, ENTRY_MIN);
        push_load(TAB_LEFT, TABLE_DEPTH - 1, ENTRY_MAX);
        push_directed_queries();
        push_random(PHASE_WORDS);
        wait_idle();

        set_geometry((1 << SIZE_W) - 1, 0, 1'b1);
        push_directed_queries();
        rx_hold_req = 1'b1;
        push_random(PHASE_WORDS);
        wait_idle();

        // negative span
        set_geometry(1, (1 << MARGIN_W) - 1, 1'b1);
        no_idle = 1'b1;
        push_random(PHASE_WORDS);
        wait_idle();
        no_idle = 1'b0;

        set_geometry((1 << SIZE_W) - 1, (1 << MARGIN_W) - 1, 1'b0);
        push_random(PHASE_WORDS);
        wait_idle();

        set_geometry(1, 0, 1'b1);
        push_random(PHASE_WORDS);
        wait_idle();

        repeat (3) begin
            set_geometry($urandom_range((1 << SIZE_W) - 1, 1),
                         $urandom_range((1 << MARGIN_W) - 1, 0), $urandom_range(1, 0));
            push_random(PHASE_WORDS);
            wait_idle();
        end

        if (fail_count == 0 && source_q.size() == 0)
            $display("[unwarp_remap_grid_generator] OK");
        else
            $display("[unwarp_remap_grid_generator] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/urg_pkg.sv
rtl/urg_tables.sv
rtl/urg_axis.sv
rtl/unwarp_remap_grid_generator.sv
verif/tb_top.sv
